[rtl/cigar_pkg.sv]
// ----------------------------------------------------------------------------
// CIGAR segment parser package
// Shared types, character codes and result helpers for the CIGAR parser.
// ----------------------------------------------------------------------------
package cigar_pkg;

	// ASCII codes of the operation letters and the digit range.
	localparam logic [7:0] SYM_ZERO = 8'h30;
	localparam logic [7:0] SYM_NINE = 8'h39;
	localparam logic [7:0] SYM_N    = 8'h4E;
	localparam logic [7:0] SYM_I    = 8'h49;
	localparam logic [7:0] SYM_D    = 8'h44;
	localparam logic [7:0] SYM_S    = 8'h53;
	localparam logic [7:0] SYM_H    = 8'h48;
	localparam logic [7:0] SYM_P    = 8'h50;

	// Saturation limits.
	localparam logic [9:0]  COUNT_MAX    = 10'd1023;
	localparam logic [16:0] READ_LEN_MAX = 17'd131071;
	localparam logic [15:0] READ_POS_MAX = 16'hFFFF;

	// Read span end reported for an empty span starting at zero.
	localparam logic [16:0] READ_END_EMPTY = 17'h1FFFF;

	// Result queue geometry.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// One result item.
	typedef struct packed {
		logic               ref_valid;
		logic [31:0]        ref_span_start;
		logic [31:0]        ref_span_end;
		logic               read_valid;
		logic [15:0]        read_span_start;
		logic signed [16:0] read_span_end;
		logic [9:0]         span_count;
		logic               end_of_string;
	} result_t;

	// Saturating increment of the span counter.
	function automatic logic [9:0] count_up(input logic [9:0] c);
		return (c < COUNT_MAX) ? c + 10'd1 : COUNT_MAX;
	endfunction

	// Build a result from span bases and lengths; invalid spans report zero.
	function automatic result_t make_result(
		input logic        rv,
		input logic        dv,
		input logic [31:0] rbase,
		input logic [31:0] rlen,
		input logic [15:0] dbase,
		input logic [16:0] dlen,
		input logic [9:0]  cnt,
		input logic        eos
	);
		logic [17:0] dsum;
		logic [17:0] dlast;
		result_t     r;
		dsum  = {2'b00, dbase} + {1'b0, dlen};
		dlast = dsum - 18'd1;
		r.ref_valid       = rv;
		r.ref_span_start  = rv ? rbase : 32'd0;
		r.ref_span_end    = rv ? (rbase + rlen - 32'd1) : 32'd0;
		r.read_valid      = dv;
		r.read_span_start = dv ? dbase : 16'd0;
		if (!dv) begin
			r.read_span_end = 17'd0;
		end else if (dsum == 18'd0) begin
			r.read_span_end = READ_END_EMPTY;
		end else if (dlast > {2'b00, READ_POS_MAX}) begin
			r.read_span_end = {1'b0, READ_POS_MAX};
		end else begin
			r.read_span_end = dlast[16:0];
		end
		r.span_count    = cnt;
		r.end_of_string = eos;
		return r;
	endfunction

endpackage

[rtl/cigar_segment_parser_core.sv]
// ----------------------------------------------------------------------------
// CIGAR segment parser core
// Splits a CIGAR string, one character per transfer, into reference and
// read spans at every N operation and at the end of the string.
// ----------------------------------------------------------------------------
// The block takes one CIGAR character per cycle and sustains one transfer
// per cycle while the input is not stalled. A character goes into an input
// register; when it leaves that register the parse state (run length, span
// bases and lengths, span count) is updated and zero, one or two results
// (an N span, then the closing result on the last character) enter a
// four-entry result queue. The input stalls only while a character waits in
// the input register and the result queue holds more than two results, so a
// stalled output fills the queue and then stops the input; the stall to the
// input side is driven from registers alone.
module cigar_segment_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	// Input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               first,
	input  logic [30:0]        align_start,
	input  logic [7:0]         symbol,
	input  logic               last,
	// Output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ref_valid,
	output logic [31:0]        ref_span_start,
	output logic [31:0]        ref_span_end,
	output logic               read_valid,
	output logic [15:0]        read_span_start,
	output logic signed [16:0] read_span_end,
	output logic [9:0]         span_count,
	output logic               end_of_string
);

	// Input register stage.
	logic        valid_s1;
	logic        first_s1;
	logic [30:0] align_start_s1;
	logic [7:0]  symbol_s1;
	logic        last_s1;

	// Parse state.
	logic [31:0] run_q;
	logic [31:0] ref_base_q;
	logic [31:0] ref_len_q;
	logic [15:0] read_base_q;
	logic [16:0] read_len_q;
	logic [9:0]  spans_q;

	// Result queue.
	cigar_pkg::result_t               fifo_mem [cigar_pkg::FIFO_DEPTH];
	logic [cigar_pkg::FIFO_AW-1:0]    head_q;
	logic [cigar_pkg::FIFO_AW-1:0]    tail_q;
	logic [cigar_pkg::FIFO_AW:0]      count_q;

	logic fifo_room;
	logic advance;
	logic s1_load;
	logic pop;
	logic push_a;
	logic push_b;
	logic [cigar_pkg::FIFO_AW:0] push_n;

	// Effective state after a possible restart on the first character.
	logic [31:0] run_e;
	logic [31:0] ref_base_e;
	logic [31:0] ref_len_e;
	logic [15:0] read_base_e;
	logic [16:0] read_len_e;
	logic [9:0]  spans_e;

	// State after the symbol is processed.
	logic [31:0] run_p;
	logic [31:0] ref_base_p;
	logic [31:0] ref_len_p;
	logic [15:0] read_base_p;
	logic [16:0] read_len_p;
	logic [9:0]  spans_p;

	logic        is_digit;
	logic        is_n;
	logic        is_clip;
	logic        add_ref;
	logic        add_read;
	logic [31:0] run_x10;
	logic [17:0] rb_sum;
	logic [32:0] rl_sum;
	logic        rv_b;
	logic        dv_b;
	logic [9:0]  cnt_b;

	cigar_pkg::result_t res_a;
	cigar_pkg::result_t res_b;
	cigar_pkg::result_t head_res;

	// Handshake control: the input register empties into the queue when two
	// entries are free.
	assign fifo_room = (count_q <= (cigar_pkg::FIFO_AW+1)'(cigar_pkg::FIFO_DEPTH - 2));
	assign advance   = valid_s1 && fifo_room;
	assign in_stall  = valid_s1 && !fifo_room;
	assign s1_load   = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load) begin
			first_s1       <= first;
			align_start_s1 <= align_start;
			symbol_s1      <= symbol;
			last_s1        <= last;
		end
	end

	// Restart on the first character of a string.
	always_comb begin
		if (first_s1) begin
			run_e       = 32'd0;
			ref_base_e  = {1'b0, align_start_s1};
			ref_len_e   = 32'd0;
			read_base_e = 16'd0;
			read_len_e  = 17'd0;
			spans_e     = 10'd0;
		end else begin
			run_e       = run_q;
			ref_base_e  = ref_base_q;
			ref_len_e   = ref_len_q;
			read_base_e = read_base_q;
			read_len_e  = read_len_q;
			spans_e     = spans_q;
		end
	end

	// Symbol decode.
	assign is_digit = (symbol_s1 >= cigar_pkg::SYM_ZERO) && (symbol_s1 <= cigar_pkg::SYM_NINE);
	assign is_n     = (symbol_s1 == cigar_pkg::SYM_N);
	assign is_clip  = (symbol_s1 == cigar_pkg::SYM_S) || (symbol_s1 == cigar_pkg::SYM_H) ||
	                  (symbol_s1 == cigar_pkg::SYM_P);
	assign add_ref  = !is_clip && (symbol_s1 != cigar_pkg::SYM_I);
	assign add_read = !is_clip && (symbol_s1 != cigar_pkg::SYM_D);

	// Run length times ten plus the digit, as shifts and adds.
	assign run_x10 = {run_e[28:0], 3'b000} + {run_e[30:0], 1'b0} + {28'd0, symbol_s1[3:0]};
	assign rb_sum  = {2'b00, read_base_e} + {1'b0, read_len_e};
	assign rl_sum  = {16'd0, read_len_e} + {1'b0, run_e};

	// State update for one symbol.
	always_comb begin
		run_p       = run_e;
		ref_base_p  = ref_base_e;
		ref_len_p   = ref_len_e;
		read_base_p = read_base_e;
		read_len_p  = read_len_e;
		spans_p     = spans_e;
		if (is_digit) begin
			run_p = run_x10;
		end else if (is_n) begin
			spans_p     = cigar_pkg::count_up(spans_e);
			ref_base_p  = ref_base_e + ref_len_e + run_e;
			read_base_p = (rb_sum > {2'b00, cigar_pkg::READ_POS_MAX}) ?
			              cigar_pkg::READ_POS_MAX : rb_sum[15:0];
			ref_len_p   = 32'd0;
			read_len_p  = 17'd0;
			run_p       = 32'd0;
		end else begin
			if (add_ref) begin
				ref_len_p = ref_len_e + run_e;
			end
			if (add_read) begin
				read_len_p = (rl_sum > {16'd0, cigar_pkg::READ_LEN_MAX}) ?
				             cigar_pkg::READ_LEN_MAX : rl_sum[16:0];
			end
			run_p = 32'd0;
		end
	end

	// Result of an N, and the closing result of the last character.
	assign res_a = cigar_pkg::make_result(1'b1, 1'b1, ref_base_e, ref_len_e, read_base_e,
	                                      read_len_e, spans_p, 1'b0);
	assign rv_b  = (ref_len_p != 32'd0);
	assign dv_b  = (read_len_p != 17'd0);
	assign cnt_b = rv_b ? cigar_pkg::count_up(spans_p) : spans_p;
	assign res_b = cigar_pkg::make_result(rv_b, dv_b, ref_base_p, ref_len_p, read_base_p,
	                                      read_len_p, cnt_b, 1'b1);

	// Parse state registers; the end of a string clears all but the reference base.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= 32'd0;
			ref_base_q  <= 32'd0;
			ref_len_q   <= 32'd0;
			read_base_q <= 16'd0;
			read_len_q  <= 17'd0;
			spans_q     <= 10'd0;
		end else if (advance) begin
			ref_base_q <= ref_base_p;
			if (last_s1) begin
				run_q       <= 32'd0;
				ref_len_q   <= 32'd0;
				read_base_q <= 16'd0;
				read_len_q  <= 17'd0;
				spans_q     <= 10'd0;
			end else begin
				run_q       <= run_p;
				ref_len_q   <= ref_len_p;
				read_base_q <= read_base_p;
				read_len_q  <= read_len_p;
				spans_q     <= spans_p;
			end
		end
	end

	// Queue writes: the N result goes first, the closing result after it.
	assign push_a = advance && is_n;
	assign push_b = advance && last_s1;
	assign push_n = (cigar_pkg::FIFO_AW+1)'(push_a) + (cigar_pkg::FIFO_AW+1)'(push_b);

	always_ff @(posedge clk) begin
		if (push_a) begin
			fifo_mem[tail_q] <= res_a;
		end
		if (push_b) begin
			fifo_mem[tail_q + cigar_pkg::FIFO_AW'(push_a)] <= res_b;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + push_n[cigar_pkg::FIFO_AW-1:0];
			head_q  <= head_q + cigar_pkg::FIFO_AW'(pop);
			count_q <= count_q + push_n - (cigar_pkg::FIFO_AW+1)'(pop);
		end
	end

	// Head of the queue drives the output fields.
	assign head_res        = fifo_mem[head_q];
	assign ref_valid       = head_res.ref_valid;
	assign ref_span_start  = head_res.ref_span_start;
	assign ref_span_end    = head_res.ref_span_end;
	assign read_valid      = head_res.read_valid;
	assign read_span_start = head_res.read_span_start;
	assign read_span_end   = head_res.read_span_end;
	assign span_count      = head_res.span_count;
	assign end_of_string   = head_res.end_of_string;

	// The queue never holds more entries than it has.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (cigar_pkg::FIFO_AW+1)'(cigar_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	// The fill count follows pushes and pops exactly.
	a_fifo_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + $past(push_n) - (cigar_pkg::FIFO_AW+1)'($past(pop)))
		else $error("result queue count mismatch");

	// A last character always leaves a result waiting in the next cycle.
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> out_valid)
		else $error("closing result missing");

	// The input stalls only while an item waits in the input register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && !fifo_room)
		else $error("input stalled without cause");

endmodule

[dv/tb_cigar_segment_parser_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CIGAR segment parser core testbench
// Streams CIGAR characters into the parser and checks every span result
// against a cycle-free behavioral predictor. Directed strings cover the
// operation letters, overflow and saturation corners. Random strings,
// broken strings and byte noise follow. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_cigar_segment_parser_core;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 60;
	localparam int QUIET_ITEMS  = 300;
	localparam int DRAIN_CYCLES = 20;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic               first = 1'b0;
	logic [30:0]        align_start = '0;
	logic [7:0]         symbol = '0;
	logic               last = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               ref_valid;
	logic [31:0]        ref_span_start;
	logic [31:0]        ref_span_end;
	logic               read_valid;
	logic [15:0]        read_span_start;
	logic signed [16:0] read_span_end;
	logic [9:0]         span_count;
	logic               end_of_string;

	// Parser state as the predictor sees it.
	logic [31:0] run_acc;
	logic [31:0] cur_ref_base;
	logic [31:0] cur_ref_len;
	logic [15:0] cur_read_base;
	logic [16:0] cur_read_len;
	logic [9:0]  spans_emitted;

	cigar_pkg::result_t pending_spans[$];
	cigar_pkg::result_t want;
	int                 errors = 0;
	int                 items_sent = 0;
	int                 cycle_count = 0;
	int                 idle_pct = 12;

	cigar_segment_parser_core u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.first           (first),
		.align_start     (align_start),
		.symbol          (symbol),
		.last            (last),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ref_valid       (ref_valid),
		.ref_span_start  (ref_span_start),
		.ref_span_end    (ref_span_end),
		.read_valid      (read_valid),
		.read_span_start (read_span_start),
		.read_span_end   (read_span_end),
		.span_count      (span_count),
		.end_of_string   (end_of_string)
	);

	// Clock generation.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Random back-pressure on the result channel.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	// Clear everything that belongs to one string; the reference base stays.
	function automatic void clear_string_state();
		run_acc       = '0;
		cur_ref_len   = '0;
		cur_read_base = '0;
		cur_read_len  = '0;
		spans_emitted = '0;
	endfunction

	function automatic logic [9:0] next_span_count(input logic [9:0] c);
		return (c == 10'h3FF) ? c : c + 10'd1;
	endfunction

	// Append one predicted result to the scoreboard queue.
	function automatic void queue_span(input cigar_pkg::result_t r);
		pending_spans.insert(pending_spans.size(), r);
	endfunction

	// Build one span result from the current spans; invalid spans read as zero.
	function automatic cigar_pkg::result_t current_spans(input logic rv, input logic dv,
			input logic eos);
		cigar_pkg::result_t r;
		longint             read_last;
		read_last = longint'(cur_read_base) + longint'(cur_read_len) - 1;
		if (read_last > 65535)
			read_last = 65535;
		r.ref_valid       = rv;
		r.ref_span_start  = rv ? cur_ref_base : 32'd0;
		r.ref_span_end    = rv ? cur_ref_base + cur_ref_len - 32'd1 : 32'd0;
		r.read_valid      = dv;
		r.read_span_start = dv ? cur_read_base : 16'd0;
		r.read_span_end   = dv ? read_last[16:0] : 17'd0;
		r.span_count      = spans_emitted;
		r.end_of_string   = eos;
		return r;
	endfunction

	// Predict the spans that one accepted character produces.
	function automatic void parse_symbol(input logic f, input logic [30:0] start,
			input logic [7:0] s, input logic l);
		logic [17:0] next_read;
		longint      read_sum;
		logic        clip;
		if (f) begin
			clear_string_state();
			cur_ref_base = {1'b0, start};
		end
		if (s >= cigar_pkg::SYM_ZERO && s <= cigar_pkg::SYM_NINE) begin
			run_acc = run_acc * 32'd10 + {24'd0, s} - {24'd0, cigar_pkg::SYM_ZERO};
		end else if (s == cigar_pkg::SYM_N) begin
			spans_emitted = next_span_count(spans_emitted);
			queue_span(current_spans(1'b1, 1'b1, 1'b0));
			cur_ref_base  = cur_ref_base + cur_ref_len + run_acc;
			next_read     = {2'b00, cur_read_base} + {1'b0, cur_read_len};
			cur_read_base = (next_read > 18'd65535) ? 16'hFFFF : next_read[15:0];
			cur_ref_len   = '0;
			cur_read_len  = '0;
			run_acc       = '0;
		end else begin
			clip = (s == cigar_pkg::SYM_S) || (s == cigar_pkg::SYM_H) ||
				(s == cigar_pkg::SYM_P);
			if (!clip && s != cigar_pkg::SYM_I)
				cur_ref_len = cur_ref_len + run_acc;
			if (!clip && s != cigar_pkg::SYM_D) begin
				read_sum     = longint'(cur_read_len) + longint'(run_acc);
				cur_read_len = (read_sum > 131071) ? cigar_pkg::READ_LEN_MAX : read_sum[16:0];
			end
			run_acc = '0;
		end
		if (l) begin
			if (cur_ref_len != 0)
				spans_emitted = next_span_count(spans_emitted);
			queue_span(current_spans(cur_ref_len != 0, cur_read_len != 0, 1'b1));
			clear_string_state();
		end
	endfunction

	// Send one character; returns on the edge where the transfer happens.
	task automatic send_symbol(input logic f, input logic [30:0] start,
			input logic [7:0] s, input logic l);
		logic taken;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		first       <= f;
		align_start <= start;
		symbol      <= s;
		last        <= l;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		parse_symbol(f, start, s, l);
		items_sent++;
	endtask

	// Send a text as one string, optionally without its opening or closing mark.
	task automatic send_string(input string text, input logic [30:0] start,
			input logic with_first, input logic with_last);
		int k;
		for (k = 0; k < text.len(); k++)
			send_symbol(with_first && k == 0, start, text[k],
				with_last && k == text.len() - 1);
	endtask

	// Random CIGAR text: run lengths from empty to beyond 32 bits.
	function automatic string make_cigar();
		string           text;
		string           letters;
		int              k;
		int              pick;
		longint unsigned len;
		byte             op;
		text    = "";
		letters = "MIDNSHP=X";
		for (k = $urandom_range(1, 8); k > 0; k--) begin
			pick = $urandom_range(99);
			if (pick < 8)
				len = {$urandom, $urandom} % 64'd100000000000;
			else if (pick < 18)
				len = $urandom_range(0, 200000);
			else
				len = $urandom_range(1, 999);
			op = ($urandom_range(9) == 0) ? byte'($urandom_range(33, 126))
				: letters[$urandom_range(8)];
			if (pick >= 95)
				text = $sformatf("%s%c", text, op);
			else
				text = $sformatf("%s%0d%c", text, len, op);
		end
		return text;
	endfunction

	function automatic logic [30:0] random_start();
		if ($urandom_range(4) == 0)
			return 31'h7FFFFFFF - 31'($urandom_range(0, 1000));
		return 31'($urandom_range(1, 32'h7FFFFFFF));
	endfunction

	// Characters before any first mark continue from the reset state.
	task automatic test_missing_first();
		send_string("4M", 31'd77, 1'b0, 1'b1);
	endtask

	// The D, N, I, S, H, P and = letters, an empty read span at N, unknown bytes,
	// a run at the 32-bit maximum, reference wrap, read saturation and a final N.
	task automatic test_directed_ops();
		send_string("3DN2I1S1HP4=", 31'd1, 1'b1, 1'b0);
		send_symbol(1'b0, 31'd0, 8'hFF, 1'b1);
		send_string("4294967295", 31'h7FFFFFFF, 1'b1, 1'b0);
		send_symbol(1'b0, 31'd0, 8'h00, 1'b0);
		send_symbol(1'b0, 31'd0, cigar_pkg::SYM_N, 1'b1);
	endtask

	// A long run of N operations drives the span count into saturation.
	// The opening stretch runs with no idling on either side.
	task automatic test_span_count_saturation();
		int k;
		idle_pct = 0;
		send_symbol(1'b1, 31'd5000, cigar_pkg::SYM_N, 1'b0);
		for (k = 0; k < 1024; k++) begin
			if (k == QUIET_ITEMS)
				idle_pct = 12;
			send_symbol(1'b0, 31'd0, cigar_pkg::SYM_N, k == 1023);
		end
		idle_pct = 12;
	endtask

	// Mostly well-formed strings, then broken strings and byte noise.
	task automatic test_random_strings();
		int goal;
		int pick;
		goal = items_sent + RANDOM_ITEMS;
		while (items_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				send_string(make_cigar(), random_start(), 1'b1, 1'b1);
			end else if (pick < 90) begin
				send_string(make_cigar(), random_start(), 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else begin
				repeat ($urandom_range(1, 6))
					send_symbol($urandom_range(9) == 0, 31'($urandom),
						8'($urandom_range(255)), $urandom_range(9) == 0);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [31:0] exp_val,
			input logic [31:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
				exp_val, act_val);
		end
	endtask

	// Result checker: a transfer seen here completes at the next rising edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_spans.size() == 0) begin
				errors++;
				$display("%0t: result transfer with no expected result, actual %0h", $time,
					{ref_valid, ref_span_start, ref_span_end, read_valid, read_span_start,
					read_span_end, span_count, end_of_string});
			end else begin
				want = pending_spans.pop_front();
				check_field("ref_valid", 32'(want.ref_valid), 32'(ref_valid));
				check_field("ref_span_start", want.ref_span_start, ref_span_start);
				check_field("ref_span_end", want.ref_span_end, ref_span_end);
				check_field("read_valid", 32'(want.read_valid), 32'(read_valid));
				check_field("read_span_start", 32'(want.read_span_start),
					32'(read_span_start));
				check_field("read_span_end", 32'(unsigned'(want.read_span_end)),
					32'(unsigned'(read_span_end)));
				check_field("span_count", 32'(want.span_count), 32'(span_count));
				check_field("end_of_string", 32'(want.end_of_string), 32'(end_of_string));
			end
		end
	end

	// Test sequence.
	initial begin
		run_acc      = '0;
		cur_ref_base = '0;
		clear_string_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_missing_first();
		test_directed_ops();
		test_span_count_saturation();
		test_random_strings();
		in_valid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
